// ===== design/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// types and codes shared by the sorted tuple id store
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_LOOKUP = 3'd1;
  localparam logic [2:0] OP_BEGIN  = 3'd2;
  localparam logic [2:0] OP_STEP   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ORDER   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BUSY    = 3'd3;
  localparam logic [2:0] ST_NO_SCAN = 3'd4;

  localparam logic CFG_ENTRY_LIMIT  = 1'b0;
  localparam logic CFG_PAGE_RESERVE = 1'b1;

  localparam int KEY_W = 48;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] in_block;
    logic [15:0] in_offset;
  } sts_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        found;
    logic [31:0] out_block;
    logic [15:0] out_offset;
    logic        last_of_block;
    logic        end_of_scan;
    logic [16:0] entry_count;
    logic        near_full;
  } sts_out_t;

endpackage

// ===== design/sts_ram.sv =====
// ----------------------------------------------------------------------------
// sts_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module sts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/sorted_tuple_id_store.sv =====
// ----------------------------------------------------------------------------
// sorted_tuple_id_store
// sorted append-only store of tuple ids with binary-search lookup and scan
// ----------------------------------------------------------------------------
// usage:
//   pulse start with cmd (opcode, block, offset) while busy is low; the
//   command is taken at that edge and busy rises the next cycle.
//   exactly one result beat follows, shown for one cycle with done high;
//   the receiver cannot stall it.
//   cfg_we/cfg_index/cfg_data write entry_limit (0) or page_reserve (1)
//   while idle; other indexes are ignored.
// command flow:
//   append, begin scan, clear and unused opcodes: exec state, then done.
//   scan step: exec, current entry read, then next entry read for the
//   last-of-block flag unless the current entry is the last (one ram port).
//   lookup: exec, then a probe and a compare state per probe; the binary
//   search does one ram read per probe, at most log2(CAPACITY)+1 probes.
//   the next command may start the cycle after done.
// reset:
//   counts, scan state and last key clear at once; the ram keeps its
//   contents, only entries below the count are ever read, no clearing pass.
// ----------------------------------------------------------------------------
module sorted_tuple_id_store #(
  parameter int CAPACITY = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sts_pkg::sts_in_t  cmd,
  output logic              busy,
  output logic              done,
  output sts_pkg::sts_out_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [16:0]       cfg_data
);
  import sts_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  // states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_SCUR  = 3'd4;
  localparam logic [2:0] S_SNEXT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]  state, state_next;
  sts_in_t     req;
  logic [CW-1:0] count;
  logic        scan_active;
  logic [CW-1:0] scan_pos;
  logic [KEY_W-1:0] last_key;
  logic [16:0] entry_limit;
  logic [11:0] page_reserve;
  logic [CW-1:0] lo, hi;
  sts_out_t    res;
  sts_out_t    exec_res;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  sts_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic [KEY_W-1:0] key;
  assign key = {req.in_block, req.in_offset};

  logic [CW:0] sum_lh;
  logic [CW-1:0] mid;
  assign sum_lh = {1'b0, lo} + {1'b0, hi};
  assign mid    = sum_lh[CW:1];

  // count widened for compare against the 17 bit limit
  logic [CW+16:0] count_x, limit_x;
  assign count_x = {{17{1'b0}}, count};
  assign limit_x = {{CW{1'b0}}, entry_limit};

  logic full;
  assign full = (count_x >= limit_x) || (count == CW'(CAPACITY));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = key;
    ram_addr  = mid[AW-1:0];
    unique case (state)
      S_EXEC: begin
        if (req.opcode == OP_APPEND) begin
          ram_addr = count[AW-1:0];
          ram_we   = (req.in_offset != 16'd0) && !(count != '0 && key <= last_key)
                     && !full;
        end else begin
          ram_addr = scan_pos[AW-1:0];
        end
      end
      S_PROBE: ram_addr = mid[AW-1:0];
      S_SCUR:  ram_addr = scan_pos[AW-1:0];
      default: ram_addr = mid[AW-1:0];
    endcase
  end

  // near full from the final count
  function automatic logic near_calc(input logic [CW+16:0] n, input logic [CW+16:0] lim,
                                     input logic [11:0] rsv);
    logic [CW+16:0] room;
    begin
      room = (n >= lim) ? '0 : (lim - n);
      near_calc = room < {{(CW+5){1'b0}}, rsv};
    end
  endfunction

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_DONE);
  always_comb begin
    result = res;
    result.entry_count = count_x[16:0];
    result.near_full   = near_calc(count_x, limit_x, page_reserve);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit  <= 17'h10000;
      page_reserve <= 12'd291;
    end else if (cfg_we && state == S_IDLE) begin
      if (cfg_index == CFG_ENTRY_LIMIT) entry_limit <= cfg_data;
      else page_reserve <= cfg_data[11:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC: begin
        if (req.opcode == OP_LOOKUP && req.in_offset != 16'd0 && count != '0)
          state_next = S_PROBE;
        else if (req.opcode == OP_STEP && scan_active && scan_pos < count)
          state_next = S_SCUR;
        else
          state_next = S_DONE;
      end
      S_PROBE: state_next = S_CMP;
      S_CMP: begin
        if (key == ram_rdata) state_next = S_DONE;
        else if (key < ram_rdata) state_next = (lo < mid) ? S_PROBE : S_DONE;
        else state_next = (mid + 1'b1 < hi) ? S_PROBE : S_DONE;
      end
      S_SCUR:  state_next = (scan_pos < count) ? S_SNEXT : S_DONE;
      S_SNEXT: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      scan_active <= 1'b0;
      scan_pos    <= '0;
      last_key    <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        case (req.opcode)
          OP_APPEND: if (ram_we) begin
            count    <= count + 1'b1;
            last_key <= key;
          end
          OP_BEGIN: if (!scan_active) begin
            scan_active <= 1'b1;
            scan_pos    <= '0;
          end
          OP_STEP: if (scan_active) begin
            if (scan_pos >= count) scan_active <= 1'b0;
            else scan_pos <= scan_pos + 1'b1;
          end
          OP_CLEAR: begin
            count       <= '0;
            scan_active <= 1'b0;
            scan_pos    <= '0;
            last_key    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // first-cycle result: status and end of scan, all else zero
  always_comb begin
    exec_res = '0;
    case (req.opcode)
      OP_APPEND: begin
        if (req.in_offset == 16'd0 || (count != '0 && key <= last_key))
          exec_res.status = ST_ORDER;
        else if (full) exec_res.status = ST_FULL;
      end
      OP_LOOKUP: if (req.in_offset == 16'd0) exec_res.status = ST_ORDER;
      OP_BEGIN:  if (scan_active) exec_res.status = ST_BUSY;
      OP_STEP: begin
        if (!scan_active) exec_res.status = ST_NO_SCAN;
        else if (scan_pos >= count) exec_res.end_of_scan = 1'b1;
      end
      default: ;
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req <= cmd;
    end
    unique case (state)
      S_EXEC: begin
        res <= exec_res;
        lo  <= '0;
        hi  <= count;
      end
      S_CMP: begin
        if (key == ram_rdata) res.found <= 1'b1;
        else if (key < ram_rdata) hi <= mid;
        else lo <= mid + 1'b1;
      end
      S_SCUR: begin
        // ram holds the entry at the old position; scan_pos already advanced
        res.out_block  <= ram_rdata[47:16];
        res.out_offset <= ram_rdata[15:0];
        if (scan_pos >= count) res.last_of_block <= 1'b1;
      end
      S_SNEXT: begin
        if (ram_rdata[47:16] != res.out_block) res.last_of_block <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== sim/sorted_tuple_id_store_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_tuple_id_store_tb
// checks the sorted tuple id store against an in-bench predictor: directed
// corner cases, then random append, lookup and scan sequences under several
// register settings and sender idle patterns
// ----------------------------------------------------------------------------

// predicts every result beat and checks the beats that come back
class id_store_scoreboard;
  localparam int CAP = 65536;

  // shadow copy of the store and its registers
  logic [47:0] ids[$];
  logic [47:0] last_key;
  bit          scan_on;
  int unsigned scan_pos;
  int unsigned limit;
  int unsigned reserve;

  sts_pkg::sts_out_t expected_beats[$];
  int errors;
  int checked;

  function new();
    errors  = 0;
    checked = 0;
    limit   = 65536;
    reserve = 291;
    clear_store();
  endfunction

  function void clear_store();
    ids.delete();
    last_key = '0;
    scan_on  = 0;
    scan_pos = 0;
  endfunction

  function void write_reg(logic idx, logic [16:0] data);
    if (idx == sts_pkg::CFG_ENTRY_LIMIT) limit = data;
    else reserve = data[11:0];
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction

  // binary search over the shadow store
  function bit holds_key(logic [47:0] key);
    int lo, hi, mid;
    lo = 0;
    hi = ids.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (key < ids[mid]) hi = mid;
      else if (key == ids[mid]) return 1;
      else lo = mid + 1;
    end
    return 0;
  endfunction

  // an accepted command: update shadow state and queue the expected beat
  function void note_command(sts_pkg::sts_in_t c);
    sts_pkg::sts_out_t e;
    logic [47:0] key;
    int unsigned n, room;
    e   = '0;
    key = {c.in_block, c.in_offset};
    case (c.opcode)
      sts_pkg::OP_APPEND: begin
        if (c.in_offset == 0 || (ids.size() > 0 && key <= last_key)) begin
          e.status = sts_pkg::ST_ORDER;
        end else if (ids.size() >= limit || ids.size() >= CAP) begin
          e.status = sts_pkg::ST_FULL;
        end else begin
          ids.push_back(key);
          last_key = key;
        end
      end
      sts_pkg::OP_LOOKUP: begin
        if (c.in_offset == 0) e.status = sts_pkg::ST_ORDER;
        else e.found = holds_key(key);
      end
      sts_pkg::OP_BEGIN: begin
        if (scan_on) begin
          e.status = sts_pkg::ST_BUSY;
        end else begin
          scan_on  = 1;
          scan_pos = 0;
        end
      end
      sts_pkg::OP_STEP: begin
        if (!scan_on) begin
          e.status = sts_pkg::ST_NO_SCAN;
        end else if (scan_pos >= ids.size()) begin
          e.end_of_scan = 1;
          scan_on = 0;
        end else begin
          e.out_block  = ids[scan_pos][47:16];
          e.out_offset = ids[scan_pos][15:0];
          scan_pos++;
          e.last_of_block = (scan_pos >= ids.size()) ||
                            (ids[scan_pos][47:16] != e.out_block);
        end
      end
      sts_pkg::OP_CLEAR: clear_store();
      default: ;
    endcase
    n    = ids.size();
    room = (n >= limit) ? 0 : limit - n;
    e.entry_count = n[16:0];
    e.near_full   = room < reserve;
    expected_beats.push_back(e);
  endfunction

  function void report(string field, longint unsigned e, longint unsigned a);
    errors++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, e, a);
  endfunction

  // a result beat: compare field by field with the oldest expectation
  function void check_result(sts_pkg::sts_out_t a);
    sts_pkg::sts_out_t e;
    if (expected_beats.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none actual %h", $time, a);
      return;
    end
    e = expected_beats.pop_front();
    checked++;
    if (a.status !== e.status) report("status", e.status, a.status);
    if (a.found !== e.found) report("found", e.found, a.found);
    if (a.out_block !== e.out_block) report("out_block", e.out_block, a.out_block);
    if (a.out_offset !== e.out_offset) report("out_offset", e.out_offset, a.out_offset);
    if (a.last_of_block !== e.last_of_block)
      report("last_of_block", e.last_of_block, a.last_of_block);
    if (a.end_of_scan !== e.end_of_scan)
      report("end_of_scan", e.end_of_scan, a.end_of_scan);
    if (a.entry_count !== e.entry_count)
      report("entry_count", e.entry_count, a.entry_count);
    if (a.near_full !== e.near_full) report("near_full", e.near_full, a.near_full);
  endfunction
endclass

module sorted_tuple_id_store_tb;
  import sts_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  sts_in_t     cmd;
  logic        busy;
  logic        done;
  sts_out_t    result;
  logic        cfg_we;
  logic        cfg_index;
  logic [16:0] cfg_data;

  id_store_scoreboard sb;
  int cmd_count;
  int reg_writes;
  int idle_pct;

  sorted_tuple_id_store dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // every done beat is taken at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic sts_in_t mk(logic [2:0] op, logic [31:0] blk, logic [15:0] off);
    sts_in_t c;
    c.opcode    = op;
    c.in_block  = blk;
    c.in_offset = off;
    return c;
  endfunction

  // hold start high with the command until the block takes it
  task automatic send(sts_in_t c);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    sb.note_command(c);
    cmd_count++;
  endtask

  // stop sending and wait for every outstanding beat
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  // next append key: mostly ascending, sometimes a random jump that may be
  // out of order; a key past the 48-bit space turns into a clear instead
  task automatic append_next();
    longint unsigned base, k;
    int mode;
    base = (sb.ids.size() == 0) ? 64'd0 : 64'(sb.last_key);
    mode = $urandom_range(9);
    if (mode < 5)
      k = base + $urandom_range(1, 4);
    else if (mode < 8)
      k = (((base >> 16) + $urandom_range(1, 3)) << 16) | $urandom_range(1, 65535);
    else
      k = 64'({$urandom, 16'($urandom)});
    if (k >= 64'h1_0000_0000_0000) send(mk(OP_CLEAR, $urandom, 16'($urandom)));
    else send(mk(OP_APPEND, k[47:16], k[15:0]));
  endtask

  task automatic lookup_some();
    logic [47:0] k;
    repeat ($urandom_range(1, 3)) begin
      if (sb.ids.size() > 0 && $urandom_range(1)) begin
        k = sb.ids[$urandom_range(sb.ids.size() - 1)];
        if ($urandom_range(2) == 0) k = k + 1;
      end else begin
        k = {$urandom, 16'($urandom)};
      end
      send(mk(OP_LOOKUP, k[47:16], k[15:0]));
    end
  endtask

  // begin a scan and walk it to its end, now and then appending mid-scan
  task automatic scan_through();
    int steps;
    send(mk(OP_BEGIN, $urandom, 16'($urandom)));
    steps = sb.ids.size() - sb.scan_pos + 1 + $urandom_range(1);
    repeat (steps) begin
      if ($urandom_range(9) == 0) append_next();
      send(mk(OP_STEP, $urandom, 16'($urandom)));
    end
  endtask

  task automatic random_burst();
    int r;
    r = $urandom_range(99);
    if (sb.ids.size() > 120) send(mk(OP_CLEAR, $urandom, 16'($urandom)));
    else if (r < 45) repeat ($urandom_range(1, 6)) append_next();
    else if (r < 65) lookup_some();
    else if (r < 85) scan_through();
    else if (r < 97) send(mk(3'($urandom), $urandom, 16'($urandom)));
    else send(mk(OP_CLEAR, $urandom, 16'($urandom)));
  endtask

  task automatic run_phase(int limit, int reserve, int pct, int n_items);
    int target;
    write_reg(CFG_ENTRY_LIMIT, limit[16:0]);
    write_reg(CFG_PAGE_RESERVE, reserve[16:0]);
    send(mk(OP_CLEAR, 0, 0));
    idle_pct = pct;
    target   = cmd_count + n_items;
    while (cmd_count < target) begin
      random_burst();
      // with 61 percent idle, hold off mid-phase until every beat is back, if the count hits the half-way mark
      if (pct == 61 && cmd_count == target - n_items / 2) drain();
    end
    idle_pct = 0;
  endtask

  initial begin
    sb         = new();
    cmd_count  = 0;
    reg_writes = 0;
    idle_pct   = 0;
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    cfg_we     = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at the reset register values
    send(mk(OP_STEP, 0, 0));                    // step with no scan
    send(mk(OP_LOOKUP, 0, 1));                  // lookup on empty store
    send(mk(OP_LOOKUP, 5, 0));                  // invalid lookup
    send(mk(OP_APPEND, 0, 0));                  // invalid append
    send(mk(OP_APPEND, 0, 1));                  // smallest key
    send(mk(OP_APPEND, 0, 1));                  // equal key, out of order
    send(mk(OP_APPEND, 0, 16'hFFFF));
    send(mk(OP_APPEND, 1, 7));
    send(mk(OP_APPEND, 1, 3));                  // lower key, out of order
    send(mk(OP_APPEND, 1, 9));
    send(mk(OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF)); // largest key
    send(mk(OP_LOOKUP, 1, 9));
    send(mk(OP_LOOKUP, 1, 8));
    send(mk(OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF));
    send(mk(OP_BEGIN, 0, 0));
    send(mk(OP_BEGIN, 0, 0));                   // begin while scanning
    repeat (3) send(mk(OP_STEP, 0, 0));
    send(mk(OP_LOOKUP, 0, 16'hFFFF));
    repeat (3) send(mk(OP_STEP, 0, 0));         // runs past the end
    send(mk(3'd5, 32'hAAAA_5555, 16'h5A5A));    // unused opcodes
    send(mk(3'd7, 32'h5555_AAAA, 16'hA5A5));
    send(mk(OP_CLEAR, 0, 0));
    send(mk(OP_STEP, 0, 0));                    // scan gone after clear

    // random part over register settings and sender idle patterns
    run_phase(8, 1, 0, 125);
    run_phase(0, 2048, 61, 125);
    run_phase(65536, 2048, 0, 125);
    run_phase(40, 16, 23, 125);
    run_phase(65535, 1, 61, 125);
    run_phase(130, 4095, 0, 125);

    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d commands, %0d result beats checked, %0d register writes",
             cmd_count, sb.checked, reg_writes);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("sorted_tuple_id_store test passed");
    else
      $display("sorted_tuple_id_store test failed");
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #3ms;
    $display("sorted_tuple_id_store test failed");
    $finish;
  end
endmodule
